// ===== hdl/sine_cosine_poly_approx_defines.svh =====
// Assertion macros shared by the sine/cosine approximation RTL.
`ifndef SINE_COSINE_POLY_APPROX_DEFINES_SVH
`define SINE_COSINE_POLY_APPROX_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sine/cosine block: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sine/cosine block: next-cycle check failed");

`endif

// ===== hdl/scpa_pkg.sv =====
// Types and fixed-point constants for the sine/cosine approximation block.
package scpa_pkg;

    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;
    localparam int QF      = 30;

    localparam int WRAP_W = 37;
    localparam int OPND_W = 34;
    localparam int PROD_W = 2 * OPND_W;
    localparam int RND_W  = PROD_W - QF;
    localparam int X2_W   = 33;
    localparam int T_W    = 30;
    localparam int XX2_W  = 34;
    localparam int R_W    = 33;

    localparam logic signed [WRAP_W-1:0] Q_PI      = 37'sd3373259426;
    localparam logic signed [WRAP_W-1:0] Q_HALF_PI = 37'sd1686629713;
    localparam logic signed [WRAP_W-1:0] Q_TWO_PI  = 37'sd6746518853;
    localparam logic signed [WRAP_W-1:0] Q_LIMIT   = 37'sd35433480192;

    localparam logic signed [OPND_W-1:0] Q_C3 = -34'sd178946388;
    localparam logic signed [OPND_W-1:0] Q_C5 = 34'sd8925335;
    localparam logic signed [OPND_W-1:0] Q_C7 = -34'sd198558;

    typedef enum logic [2:0] {
        MUL_X_X,
        MUL_X2_C7,
        MUL_X2_T,
        MUL_X_X2,
        MUL_XX2_T
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_X2,
        WB_T_C5,
        WB_T_C3,
        WB_XX2,
        WB_R
    } wb_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FOLD,
        ST_SQ,
        ST_SQ_WB,
        ST_P7,
        ST_P7_WB,
        ST_P5,
        ST_P5_WB,
        ST_CUBE_WB,
        ST_TERM,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     wrap;
        logic     fold;
        logic     out_load;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic above_pi;
        logic below_neg_pi;
    } dp_stat_t;

endpackage

// ===== hdl/scpa_if.sv =====
// Request and response channel interfaces of the sine/cosine approximation block.
interface scpa_req_if import scpa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, cmd, angle, input ready);
    modport sink (input valid, cmd, angle, output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink (input valid, value, range_error, output ready);
endinterface

// ===== hdl/scpa_dp.sv =====
// Datapath: angle scaling, range check, wrap and fold, shared multiplier and output rounding.
module scpa_dp import scpa_pkg::*; #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                      clk,
    input  dp_cmd_t                   ctl,
    input  logic                      req_cmd,
    input  logic signed [ANGLE_W-1:0] req_angle,
    output dp_stat_t                  stat,
    output logic signed [VALUE_W-1:0] value,
    output logic                      range_error
);

    localparam int AngShift = QF - ANGLE_FRAC_BITS;
    localparam int ScaledW  = ANGLE_W + AngShift + 1;
    localparam int ResShift = QF - RESULT_FRAC_BITS;

    localparam logic signed [ScaledW-1:0] LimitS  = ScaledW'(Q_LIMIT);
    localparam logic signed [ScaledW-1:0] HalfPiS = ScaledW'(Q_HALF_PI);
    localparam logic signed [PROD_W-1:0]  RndHalf = PROD_W'(1) <<< (QF - 1);
    localparam logic signed [R_W-1:0]     SatLim  = R_W'(1) <<< RESULT_FRAC_BITS;

    logic signed [ScaledW-1:0] scaled;
    logic signed [ScaledW-1:0] x_full;
    logic                      range_bad;
    logic signed [OPND_W-1:0]  opnd_a;
    logic signed [OPND_W-1:0]  opnd_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [RND_W-1:0]   prod_rnd;
    logic signed [R_W-1:0]     res_shifted;
    logic signed [R_W-1:0]     res_sat;

    logic signed [WRAP_W-1:0]  x_reg;
    logic                      err_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [X2_W-1:0]    x2_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [XX2_W-1:0]   xx2_reg;
    logic signed [R_W-1:0]     r_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      range_error_reg;

    // Products are rounded to nearest with ties away from zero.
    function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + (p[PROD_W-1] ? (RndHalf - PROD_W'(1)) : RndHalf);
        return s[PROD_W-1:QF];
    endfunction

    always_comb
    begin
        scaled    = ScaledW'(req_angle) <<< AngShift;
        x_full    = scaled + (req_cmd ? HalfPiS : '0);
        range_bad = (x_full >= LimitS) || (x_full <= -LimitS);
    end

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_X_X:
            begin
                opnd_a = $signed(x_reg[OPND_W-1:0]);
                opnd_b = $signed(x_reg[OPND_W-1:0]);
            end
            MUL_X2_C7:
            begin
                opnd_a = OPND_W'(x2_reg);
                opnd_b = Q_C7;
            end
            MUL_X2_T:
            begin
                opnd_a = OPND_W'(x2_reg);
                opnd_b = OPND_W'(t_reg);
            end
            MUL_X_X2:
            begin
                opnd_a = $signed(x_reg[OPND_W-1:0]);
                opnd_b = OPND_W'(x2_reg);
            end
            MUL_XX2_T:
            begin
                opnd_a = OPND_W'(xx2_reg);
                opnd_b = OPND_W'(t_reg);
            end
            default:
            begin
                opnd_a = '0;
                opnd_b = '0;
            end
        endcase
        prod_next = opnd_a * opnd_b;
        prod_rnd  = round_q(prod_reg);
    end

    generate
        if (ResShift == 0)
        begin : g_no_shift
            assign res_shifted = r_reg;
        end
        else
        begin : g_shift
            localparam int SumW = R_W + 1;
            localparam logic signed [SumW-1:0] ResHalf = SumW'(1) <<< (ResShift - 1);
            logic signed [SumW-1:0] res_sum;
            always_comb
            begin
                res_sum = SumW'(r_reg) + (r_reg[R_W-1] ? (ResHalf - SumW'(1)) : ResHalf);
            end
            assign res_shifted = R_W'(res_sum >>> ResShift);
        end
    endgenerate

    always_comb
    begin
        if (res_shifted > SatLim)
        begin
            res_sat = SatLim;
        end
        else if (res_shifted < -SatLim)
        begin
            res_sat = -SatLim;
        end
        else
        begin
            res_sat = res_shifted;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (ctl.load)
        begin
            x_reg   <= x_full[WRAP_W-1:0];
            err_reg <= range_bad;
        end
        else if (ctl.wrap)
        begin
            if (x_reg > Q_PI)
            begin
                x_reg <= x_reg - Q_TWO_PI;
            end
            else
            begin
                x_reg <= x_reg + Q_TWO_PI;
            end
        end
        else if (ctl.fold)
        begin
            if (x_reg > Q_HALF_PI)
            begin
                x_reg <= Q_PI - x_reg;
            end
            else if (x_reg < -Q_HALF_PI)
            begin
                x_reg <= -Q_PI - x_reg;
            end
        end

        case (ctl.wb_sel)
            WB_X2:   x2_reg  <= $signed(prod_rnd[X2_W-1:0]);
            WB_T_C5: t_reg   <= T_W'(Q_C5) + $signed(prod_rnd[T_W-1:0]);
            WB_T_C3: t_reg   <= T_W'(Q_C3) + $signed(prod_rnd[T_W-1:0]);
            WB_XX2:  xx2_reg <= $signed(prod_rnd[XX2_W-1:0]);
            WB_R:    r_reg   <= $signed(x_reg[R_W-1:0]) + $signed(prod_rnd[R_W-1:0]);
            default: ;
        endcase

        if (ctl.out_load)
        begin
            value_reg       <= err_reg ? '0 : res_sat[VALUE_W-1:0];
            range_error_reg <= err_reg;
        end
    end

    assign stat.err          = err_reg;
    assign stat.above_pi     = x_reg > Q_PI;
    assign stat.below_neg_pi = x_reg < -Q_PI;
    assign value             = value_reg;
    assign range_error       = range_error_reg;

endmodule

// ===== hdl/scpa_ctrl.sv =====
// Controller state machine that sequences the datapath and owns both handshakes.
module scpa_ctrl import scpa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        ctl         = '0;
        ctl.mul_sel = MUL_X_X;
        ctl.wb_sel  = WB_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (stat.err)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.above_pi || stat.below_neg_pi)
                begin
                    ctl.wrap = 1'b1;
                end
                else
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctl.fold   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                ctl.mul_sel = MUL_X_X;
                state_next  = ST_SQ_WB;
            end
            ST_SQ_WB:
            begin
                ctl.wb_sel = WB_X2;
                state_next = ST_P7;
            end
            ST_P7:
            begin
                ctl.mul_sel = MUL_X2_C7;
                state_next  = ST_P7_WB;
            end
            ST_P7_WB:
            begin
                ctl.wb_sel = WB_T_C5;
                state_next = ST_P5;
            end
            ST_P5:
            begin
                ctl.mul_sel = MUL_X2_T;
                state_next  = ST_P5_WB;
            end
            ST_P5_WB:
            begin
                ctl.wb_sel  = WB_T_C3;
                ctl.mul_sel = MUL_X_X2;
                state_next  = ST_CUBE_WB;
            end
            ST_CUBE_WB:
            begin
                ctl.wb_sel = WB_XX2;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                ctl.mul_sel = MUL_XX2_T;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.wb_sel = WB_R;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = ctl.out_load || (out_valid_reg && !rsp_ready);
    assign rsp_valid      = out_valid_reg;

endmodule

// ===== hdl/sine_cosine_poly_approx.sv =====
// Top level of the sine/cosine minimax polynomial approximation block.
// Once a request is taken, an out-of-range angle goes straight to the output register,
// while an in-range one is wrapped into [-pi, pi] by a loop, folded and then evaluated.
// One transaction is in work at a time: a new request is taken only once the previous
// one has been loaded into the output register; all products share a single multiplier.
// A finished result waits in the output register while the next request is worked on.
// Reset empties the output register and returns the controller to idle.
`include "sine_cosine_poly_approx_defines.svh"

module sine_cosine_poly_approx import scpa_pkg::*; #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input logic        clk,
    input logic        rst_n,
    scpa_req_if.sink   req,
    scpa_rsp_if.source rsp
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    scpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    scpa_dp #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .ctl         (ctl),
        .req_cmd     (req.cmd),
        .req_angle   (req.angle),
        .stat        (stat),
        .value       (rsp.value),
        .range_error (rsp.range_error)
    );

    `SCPA_ASSERT_IMP(a_out_load_free, ctl.out_load, !rsp.valid || rsp.ready)
    `SCPA_ASSERT_IMP(a_wrap_in_range, ctl.wrap, !stat.err)
    `SCPA_ASSERT_NEXT(a_one_in_work, req.valid && req.ready, !req.ready)

endmodule

// ===== tb/sv/scpa_checker.sv =====
// Checker that predicts and compares every sine/cosine transaction of the approximation block.
module scpa_checker #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic clk,
    input  logic rst_n,
    scpa_req_if  req,
    scpa_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int    Q_FRAC       = 30;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518853;
    localparam longint LIMIT_Q30   = 33 * ONE_Q30;
    localparam longint C3_Q30      = -64'sd178946388;
    localparam longint C5_Q30      = 64'sd8925335;
    localparam longint C7_Q30      = -64'sd198558;

    typedef struct packed {
        logic signed [31:0] value;
        logic               range_error;
    } trig_result_t;

    trig_result_t trig_expected_q[$];
    int           mismatch_count = 0;
    int           pending_count  = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    function automatic longint shift_round_away(input longint v, input int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        if (s == 0)
            return v;
        mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return shift_round_away(a * b, Q_FRAC);
    endfunction

    function automatic trig_result_t approx_trig(input logic use_cos,
                                                 input logic signed [31:0] angle);
        trig_result_t res;
        longint       x;
        longint       x2;
        longint       t;
        longint       r;
        longint       lim;
        x = longint'(angle) * (longint'(1) <<< (Q_FRAC - ANGLE_FRAC_BITS));
        if (use_cos)
            x += HALF_PI_Q30;
        if (x >= LIMIT_Q30 || x <= -LIMIT_Q30)
        begin
            res.value       = '0;
            res.range_error = 1'b1;
            return res;
        end
        while (x > PI_Q30)
            x -= TWO_PI_Q30;
        while (x < -PI_Q30)
            x += TWO_PI_Q30;
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        else if (x < -HALF_PI_Q30)
            x = -PI_Q30 - x;
        x2 = mul_q30(x, x);
        t  = C5_Q30 + mul_q30(x2, C7_Q30);
        t  = C3_Q30 + mul_q30(x2, t);
        r  = x + mul_q30(mul_q30(x, x2), t);
        r  = shift_round_away(r, Q_FRAC - RESULT_FRAC_BITS);
        lim = longint'(1) <<< RESULT_FRAC_BITS;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        res.value       = r[31:0];
        res.range_error = 1'b0;
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        trig_result_t got;
        trig_result_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                trig_expected_q.push_back(approx_trig(req.cmd, req.angle));
            if (rsp.valid && rsp.ready)
            begin
                got.value       = rsp.value;
                got.range_error = rsp.range_error;
                if (trig_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction: expected none, got %0d / %0b",
                             $time, got.value, got.range_error);
                    mismatch_count++;
                end
                else
                begin
                    want = trig_expected_q.pop_front();
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, want.value, got.value);
                        mismatch_count++;
                    end
                    if (got.range_error !== want.range_error)
                    begin
                        $display("%0t: range_error mismatch: expected %0b, got %0b",
                                 $time, want.range_error, got.range_error);
                        mismatch_count++;
                    end
                end
            end
            pending_count = trig_expected_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the sine/cosine approximation block: clock, reset, stimulus and verdict.
module tb;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;
    localparam int HALF_PI_Q24      = 26353589;
    localparam int RANGE_EDGE_Q24   = 553648128;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 21;
    int   take_idle_pct = 63;
    int   mismatches;
    int   outstanding;

    scpa_req_if req_ch ();
    scpa_rsp_if rsp_ch ();

    sine_cosine_poly_approx #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    scpa_checker #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    task automatic send_angle(input logic use_cos, input logic signed [31:0] angle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= use_cos;
        req_ch.angle <= angle;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_angle();
        int sel;
        int k;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom_range(0, 2 * (RANGE_EDGE_Q24 - 1)) - (RANGE_EDGE_Q24 - 1);
        if (sel < 75)
        begin
            k = $urandom_range(0, 40) - 20;
            return k * HALF_PI_Q24 + $urandom_range(0, 64) - 32;
        end
        if (sel < 80)
            return ($urandom_range(1) ? RANGE_EDGE_Q24 : -RANGE_EDGE_Q24)
                   + $urandom_range(0, 8) - 4;
        return $urandom;
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_angle($urandom_range(1), pick_angle());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = 1'b0;
        req_ch.angle = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_angle(1'b0, 32'sd0);
        send_angle(1'b1, 32'sd0);
        send_angle(1'b0, 32'sd1);
        send_angle(1'b0, -32'sd1);
        send_angle(1'b0, 32'sh7FFFFFFF);
        send_angle(1'b1, 32'sh7FFFFFFF);
        send_angle(1'b0, 32'sh80000000);
        send_angle(1'b1, 32'sh80000000);
        send_angle(1'b0, 32'sd553648127);
        send_angle(1'b0, 32'sd553648128);
        send_angle(1'b0, -32'sd553648127);
        send_angle(1'b0, -32'sd553648128);
        send_angle(1'b1, 32'sd527294538);
        send_angle(1'b1, 32'sd527294539);
        send_angle(1'b1, -32'sd580001717);
        send_angle(1'b1, -32'sd580001718);
        send_angle(1'b0, 32'sd26353589);
        send_angle(1'b0, 32'sd26353590);
        send_angle(1'b0, -32'sd26353590);
        send_angle(1'b0, 32'sd52707179);
        send_angle(1'b0, -32'sd52707180);
        send_angle(1'b0, 32'sd105414357);
        send_angle(1'b1, -32'sd26353589);
        send_angle(1'b1, 32'sd52707179);

        send_random(700);
        send_idle_pct = 63;
        take_idle_pct = 21;
        send_random(700);
        send_idle_pct = 0;
        take_idle_pct = 0;
        send_random(600);

        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
